/* design/qdc_pkg.sv */
`timescale 1ns / 1ps

package qdc_pkg;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_READ   = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic        pin_a_first;
    logic        pin_a_second;
    logic        pin_b;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] delta;
    logic              published;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         last_ab;
    logic signed [15:0] step_count;
    logic [31:0]        last_publish_time;
  } qdc_state_t;

  localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COUNT_MIN = -16'sh8000;
  localparam logic signed [15:0] DELTA_MAX = 16'sd127;
  localparam logic signed [15:0] DELTA_MIN = -16'sd128;

endpackage

/* design/qdc_step.sv */
`timescale 1ns / 1ps

module qdc_step import qdc_pkg::*; (
  input  in_item_t   item,
  input  qdc_state_t state,
  input  logic [31:0] publish_interval_us,
  output qdc_state_t state_nxt,
  output out_item_t  result
);

  logic [1:0]  ab;
  logic        up;
  logic [31:0] elapsed;
  logic        publish;

  assign ab      = {item.pin_a_first, item.pin_b};
  assign elapsed = item.now_us - state.last_publish_time;
  assign publish = (state.step_count != 16'sd0) && (elapsed >= publish_interval_us);

  // forward order 0-1-3-2-0
  always_comb begin
    case ({state.last_ab, ab})
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: up = 1'b1;
      default:                                 up = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt        = state;
    result.delta     = 8'sd0;
    result.published = 1'b0;
    case (item.kind)
      KIND_SAMPLE: begin
        if (item.pin_a_first == item.pin_a_second && ab != state.last_ab) begin
          state_nxt.last_ab = ab;
          if (up) begin
            if (state.step_count != COUNT_MAX) begin
              state_nxt.step_count = state.step_count + 16'sd1;
            end
          end else begin
            if (state.step_count != COUNT_MIN) begin
              state_nxt.step_count = state.step_count - 16'sd1;
            end
          end
        end
      end
      KIND_READ: begin
        state_nxt.step_count = 16'sd0;
        if (publish) begin
          state_nxt.last_publish_time = item.now_us;
          result.published            = 1'b1;
          if (state.step_count > DELTA_MAX) begin
            result.delta = 8'sd127;
          end else if (state.step_count < DELTA_MIN) begin
            result.delta = -8'sd128;
          end else begin
            result.delta = state.step_count[7:0];
          end
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

endmodule

/* design/quadrature_delta_counter.sv */
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall   | in_item (in_item_t)
// out_    | output    | out_valid / out_stall | out_item (out_item_t)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data (publish interval, us)
//
// One item per cycle while out_stall does not hold the output; the result is registered behind the input register.
// Counter state updates as an item moves from the input register to the result register.
// rst_n is synchronous: clears count, last AB, last publish time and interval.
// out_stall holds the result register; the input register keeps one item behind it.

module quadrature_delta_counter import qdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  qdc_state_t  state_r;
  qdc_state_t  state_nxt;
  out_item_t   result;
  logic [31:0] interval_r;
  logic        advance;

  qdc_step u_step (
    .item                (in_item_r),
    .state               (state_r),
    .publish_interval_us (interval_r),
    .state_nxt           (state_nxt),
    .result              (result)
  );

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      interval_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (advance && in_valid_r) begin
      out_item_r <= result;
    end
  end

  a_pub_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.published |-> out_item_r.delta != 8'sd0)
    else $error("published item with zero delta");

  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.published |-> out_item_r.delta == 8'sd0)
    else $error("unpublished item with nonzero delta");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && in_item_r.kind == KIND_READ |=> state_r.step_count == 16'sd0)
    else $error("count not cleared by read");

endmodule

/* tb/sv/quadrature_delta_counter_tb.sv */
`timescale 1ns / 1ps

module quadrature_delta_counter_tb;
  import qdc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  logic        out_hold = 1'b0;
  int          idle_pct = 13;
  int          errors = 0;
  int          items_sent = 0;
  logic [1:0]  enc_ab = 2'd0;
  logic [31:0] stamp_us = 32'd5000;

  // predictor state
  logic [1:0]         model_ab;
  logic signed [15:0] model_count;
  logic [31:0]        model_last_pub;
  logic [31:0]        model_interval;
  out_item_t          expected_deltas[$];

  quadrature_delta_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("** quadrature_delta_counter: FAILED **");
    $finish;
  end

  // forward quadrature order 0-1-3-2-0
  function automatic logic [1:0] fwd_of(logic [1:0] s);
    case (s)
      2'd0: return 2'd1;
      2'd1: return 2'd3;
      2'd3: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] back_of(logic [1:0] s);
    case (s)
      2'd1: return 2'd0;
      2'd3: return 2'd1;
      2'd2: return 2'd3;
      default: return 2'd2;
    endcase
  endfunction

  function automatic out_item_t track_encoder(in_item_t it);
    out_item_t  res;
    logic [1:0] ab;
    int         cnt;
    res = '0;
    if (it.kind == KIND_SAMPLE) begin
      if (it.pin_a_first == it.pin_a_second) begin
        ab = {it.pin_a_first, it.pin_b};
        if (ab != model_ab) begin
          cnt = int'(model_count) + ((ab == fwd_of(model_ab)) ? 1 : -1);
          if (cnt > COUNT_MAX) cnt = int'(COUNT_MAX);
          if (cnt < COUNT_MIN) cnt = int'(COUNT_MIN);
          model_count = 16'(cnt);
          model_ab = ab;
        end
      end
    end else begin
      cnt = int'(model_count);
      model_count = '0;
      if (cnt != 0 && (it.now_us - model_last_pub) >= model_interval) begin
        model_last_pub = it.now_us;
        if (cnt > DELTA_MAX) cnt = int'(DELTA_MAX);
        if (cnt < DELTA_MIN) cnt = int'(DELTA_MIN);
        res.delta = 8'(cnt);
        res.published = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      model_ab = 2'd0;
      model_count = '0;
      model_last_pub = '0;
      model_interval = '0;
      expected_deltas.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_deltas.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual delta=%0d published=%0b",
                   $time, out_item.delta, out_item.published);
        end else begin
          want = expected_deltas.pop_front();
          if (out_item.delta !== want.delta) begin
            errors++;
            $display("%0t: delta expected %0d actual %0d",
                     $time, want.delta, out_item.delta);
          end
          if (out_item.published !== want.published) begin
            errors++;
            $display("%0t: published expected %0b actual %0b",
                     $time, want.published, out_item.published);
          end
        end
      end
      if (cfg_valid && cfg_ready) model_interval = cfg_data;
      if (in_valid && !in_stall)
        expected_deltas.insert(expected_deltas.size(), track_encoder(in_item));
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= out_hold || (idle_pct != 0 && $urandom_range(99) < idle_pct);
    end
  end

  task automatic send_item(input in_item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (it.kind == KIND_SAMPLE && it.pin_a_first == it.pin_a_second)
      enc_ab = {it.pin_a_first, it.pin_b};
  endtask

  task automatic sample_pins(input logic a1, input logic a2, input logic b);
    in_item_t it;
    it.kind = KIND_SAMPLE;
    it.pin_a_first = a1;
    it.pin_a_second = a2;
    it.pin_b = b;
    it.now_us = $urandom;
    send_item(it);
  endtask

  task automatic read_delta(input logic [31:0] at);
    in_item_t it;
    it.kind = KIND_READ;
    it.pin_a_first = 1'($urandom_range(1));
    it.pin_a_second = 1'($urandom_range(1));
    it.pin_b = 1'($urandom_range(1));
    it.now_us = at;
    send_item(it);
  endtask

  // positive steps turn forward, negative backward
  task automatic turn(input int steps);
    logic [1:0] nxt;
    repeat (steps < 0 ? -steps : steps) begin
      nxt = (steps > 0) ? fwd_of(enc_ab) : back_of(enc_ab);
      sample_pins(nxt[1], nxt[1], nxt[0]);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_deltas.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_interval(input logic [31:0] us);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data <= us;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_decoding();
    read_delta(32'd0);
    turn(4);
    read_delta(32'd10);
    turn(-3);
    read_delta(32'd20);
    sample_pins(1'b0, 1'b0, 1'b0);
    sample_pins(1'b1, 1'b1, 1'b1);  // jump 0 to 3
    sample_pins(1'b0, 1'b0, 1'b1);
    sample_pins(1'b1, 1'b1, 1'b0);  // jump 1 to 2
    sample_pins(1'b1, 1'b1, 1'b0);  // no change
    sample_pins(1'b0, 1'b1, 1'b1);  // bounce
    sample_pins(1'b1, 1'b0, 1'b0);  // bounce
    read_delta(32'hFFFF_FFFF);
    read_delta(32'd30);
    turn(1);
    read_delta(32'h8000_0000);
  endtask

  task automatic test_delta_clamp();
    turn(130);
    read_delta(32'd100);
    turn(-129);
    read_delta(32'd200);
  endtask

  task automatic test_publish_interval();
    set_interval(32'd100);
    turn(2);
    read_delta(32'd1000);
    turn(2);
    read_delta(32'd1050);
    turn(1);
    read_delta(32'd1100);
    turn(1);
    read_delta(32'hFFFF_FFC0);
    turn(1);
    read_delta(32'h0000_0010);
    turn(1);
    read_delta(32'h0000_0024);
    set_interval(32'hFFFF_FFFF);
    turn(1);
    read_delta(32'h0000_0023);
    turn(-1);
    read_delta(32'h0000_0022);
    turn(1);
    read_delta(32'h0000_0050);
    set_interval(32'd0);
    turn(1);
    read_delta(32'h0000_0050);
    turn(-2);
    read_delta(32'h0000_0050);
  endtask

  task automatic test_backpressure();
    fork
      begin
        out_hold <= 1'b1;
        repeat (80) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    idle_pct = 0;
    repeat (40) begin
      if ($urandom_range(3) == 0) begin
        stamp_us += $urandom_range(0, 50);
        read_delta(stamp_us);
      end else begin
        turn($urandom_range(1) ? 1 : -1);
      end
    end
    idle_pct = 13;
    wait_results();
  endtask

  task automatic test_random_motion();
    logic [31:0] spans[4];
    in_item_t    it;
    int          start;
    int          pick;
    int          steps;
    spans[0] = 32'd0;
    spans[1] = $urandom_range(1, 300);
    spans[2] = 32'hFFFF_FFFF;
    spans[3] = $urandom;
    for (int p = 0; p < 4; p++) begin
      set_interval(spans[p]);
      idle_pct = (p == 1) ? 0 : 13;
      start = items_sent;
      while (items_sent - start < 40) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          steps = $urandom_range(1, 12);
          turn($urandom_range(1) ? steps : -steps);
        end else if (pick < 80) begin
          stamp_us += $urandom_range(0, 600);
          read_delta(stamp_us);
        end else if (pick < 92) begin
          sample_pins(1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end else begin
          it.kind = item_kind_t'(1'($urandom_range(1)));
          it.pin_a_first = 1'($urandom_range(1));
          it.pin_a_second = 1'($urandom_range(1));
          it.pin_b = 1'($urandom_range(1));
          it.now_us = $urandom;
          send_item(it);
        end
      end
    end
    idle_pct = 13;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_decoding();
    test_delta_clamp();
    test_publish_interval();
    test_backpressure();
    test_random_motion();
    wait_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** quadrature_delta_counter: PASSED **");
    end else begin
      $display("** quadrature_delta_counter: FAILED **");
    end
    $finish;
  end

endmodule
